### src/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/hcg_pkg.sv
// shared types, constants and elaboration helpers for the hex cell geometry block
package hcg_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // result kinds
  typedef enum logic [1:0] {
    KIND_GAUSS    = 2'd0,
    KIND_CENTROID = 2'd1,
    KIND_EXTENT   = 2'd2
  } kind_e;

  // engine sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_INIT,
    S_OP,
    S_MUL,
    S_ACC,
    S_DMUL,
    S_DACC,
    S_ROUND,
    S_EMIT,
    S_CENT,
    S_EXT
  } eng_state_e;

  // control side of one result handed from the engine to the output register
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [2:0] index;
    logic       last;
  } res_ctrl_t;

  // fractional bits of the 1d gauss weights
  function automatic int wgt_bits(input int coord_bits);
    return ((62 - coord_bits) < 31) ? (62 - coord_bits) : 31;
  endfunction

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // integer square root, elaboration only
  function automatic longint unsigned isqrt_c(input longint unsigned n);
    longint unsigned res;
    longint unsigned rem;
    longint unsigned bit_v;
    res   = 0;
    rem   = n;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 0) begin
        if (rem >= res + bit_v) begin
          rem = rem - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // offset of the gauss point weights from one half: 2^(w-1)/sqrt(3)
  function automatic longint unsigned gauss_offset(input int w);
    longint unsigned p;
    p = longint'(1) << (2 * w - 2);
    return isqrt_c(p / 3);
  endfunction

endpackage

### src/hcg_ram.sv
// generic single write port ram with registered read
module hcg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/hcg_mul.sv
// shared signed multiplier with registered product
module hcg_mul #(
  parameter int W = 35
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  // one product per cycle
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

### src/hcg_stats.sv
// running sum, minimum and maximum per axis over the vertices of a cell
module hcg_stats #(
  parameter int COORD_BITS = hcg_pkg::COORD_BITS
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       first_i,
  input  logic [2:0][COORD_BITS-1:0] vtx_i,
  output logic [2:0][COORD_BITS-1:0] cent_o,
  output logic [2:0][COORD_BITS-1:0] ext_o
);

  localparam int C = COORD_BITS;
  localparam logic signed [C:0] LIM = {2'b00, {(C-1){1'b1}}};

  logic signed [C+2:0] sum_q [3];
  logic signed [C-1:0] mn_q  [3];
  logic signed [C-1:0] mx_q  [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [C-1:0] v;
    logic signed [C+2:0] cs;
    logic signed [C:0]   span;

    assign v = vtx_i[a];

    // accumulate on each vertex transfer, restart on the first of a cell
    always_ff @(posedge clk_i) begin
      if (we_i) begin
        if (first_i) begin
          sum_q[a] <= (C+3)'(v);
          mn_q[a]  <= v;
          mx_q[a]  <= v;
        end else begin
          sum_q[a] <= sum_q[a] + (C+3)'(v);
          if (v < mn_q[a]) mn_q[a] <= v;
          if (v > mx_q[a]) mx_q[a] <= v;
        end
      end
    end

    // centroid rounded half up, extent saturated
    always_comb begin
      cs   = sum_q[a] + (C+3)'(4);
      span = {mx_q[a][C-1], mx_q[a]} - {mn_q[a][C-1], mn_q[a]};
    end
    assign cent_o[a] = cs[3 +: C];
    assign ext_o[a]  = (span > LIM) ? LIM[C-1:0] : span[C-1:0];
  end

endmodule

### src/hcg_engine.sv
// sequencer for gauss point mapping, jacobian determinant and result emission
`include "assert_macros.svh"

module hcg_engine #(
  parameter int COORD_BITS = hcg_pkg::COORD_BITS,
  parameter int FRAC_BITS  = hcg_pkg::FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic [2:0]                  rd_addr_o,
  input  logic [3*COORD_BITS-1:0]     rd_data_i,
  input  logic [2:0][COORD_BITS-1:0]  cent_i,
  input  logic [2:0][COORD_BITS-1:0]  ext_i,
  output hcg_pkg::res_ctrl_t          res_o,
  output logic [2:0][COORD_BITS-1:0]  res_pos_o,
  output logic [63:0]                 res_weight_o,
  input  logic                        res_take_i,
  output logic                        busy_o
);

  localparam int C    = COORD_BITS;
  localparam int E    = C + 1;
  localparam int WGT  = hcg_pkg::wgt_bits(C);
  localparam longint unsigned SVAL = hcg_pkg::gauss_offset(WGT);
  localparam int MW   = hcg_pkg::max_int(C + 3, WGT + 1);
  localparam int PW   = 2 * MW;
  localparam int AW   = C + WGT + 3;
  localparam int NW   = 2 * E + 1;
  localparam int DW   = 3 * E + 3;
  localparam int L    = MW - 1;
  localparam int SH   = 3 * FRAC_BITS + 3 - 32;
  localparam int RSH  = (SH > 0) ? SH : 0;
  localparam int LSH  = (SH < 0) ? -SH : 0;
  localparam int RW   = DW + LSH;
  localparam int VW   = RW + 3;
  localparam int XW   = (VW > 64) ? VW : 65;
  localparam logic signed [RW-1:0] RND_HALF =
    (RSH > 0) ? (RW'(1) <<< ((RSH > 0) ? RSH - 1 : 0)) : '0;
  localparam logic signed [AW-1:0] LERP_HALF = AW'(1) <<< (WGT - 1);
  localparam logic signed [MW-1:0] S_CONST   = MW'(SVAL);
  // reduction target: 0..2 differentiate along that axis, this one maps position
  localparam logic [1:0] DAX_VALUE = 2'd3;

  function automatic logic [63:0] sat64(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] hi_lim;
    logic signed [XW-1:0] lo_lim;
    hi_lim = XW'(64'sh7FFF_FFFF_FFFF_FFFF);
    lo_lim = ~hi_lim;
    if (x > hi_lim) begin
      return 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (x < lo_lim) begin
      return 64'h8000_0000_0000_0000;
    end
    return x[63:0];
  endfunction

  hcg_pkg::eng_state_e state_q, state_d;
  logic [2:0] k_q, k_d;
  logic [1:0] c_q, c_d;
  logic [1:0] dax_q, dax_d;
  logic [2:0] op_q, op_d;
  logic [3:0] ld_q, ld_d;
  logic [3:0] t_q, t_d;

  logic [3*C-1:0]       base_q [8];
  logic signed [E-1:0]  q_q    [8];
  logic signed [E-1:0]  dm_q   [9];
  logic signed [C-1:0]  val_q  [3];
  logic signed [E:0]    diff_q, sum_q;
  logic signed [NW-1:0] minor_q;
  logic signed [DW-1:0] det_q;
  logic signed [VW-1:0] vol_q;
  logic [63:0]          wsat_q;

  logic [1:0]           axis;
  logic                 kbit;
  logic signed [E-1:0]  lo, hi;
  logic signed [E:0]    diff_w, sum_w;
  logic signed [AW-1:0] p_a, acc_w;
  logic signed [E-1:0]  r_w;
  logic                 q_wr, fin;
  logic [2:0]           wpos;
  logic [3:0]           dm_idx;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic [1:0]           ci, ph, ca, cb;
  logic [3:0]           ia, ib;
  logic signed [DW-1:0] p_d;
  logic signed [RW-1:0] dsh_w, rnd_w;
  logic [63:0]          vsat_w;

  // current lerp axis and weight side for this gauss point
  always_comb begin
    if (op_q < 3'd4) begin
      axis = 2'd0;
    end else if (op_q < 3'd6) begin
      axis = 2'd1;
    end else begin
      axis = 2'd2;
    end
    kbit   = k_q[axis];
    lo     = q_q[0];
    hi     = q_q[1];
    diff_w = {hi[E-1], hi} - {lo[E-1], lo};
    sum_w  = {hi[E-1], hi} + {lo[E-1], lo};
    p_a    = AW'(mul_p);
    acc_w  = (AW'(sum_q) <<< (WGT - 1)) + (kbit ? p_a : -p_a) + LERP_HALF;
    q_wr   = ((state_q == hcg_pkg::S_OP) && (axis == dax_q)) ||
             (state_q == hcg_pkg::S_ACC);
    r_w    = (state_q == hcg_pkg::S_ACC) ? acc_w[WGT +: E] : diff_w[E-1:0];
    fin    = q_wr && (op_q == 3'd6);
    wpos   = 3'd6 - op_q;
    dm_idx = 4'({2'b00, c_q} * 4'd3) + {2'b00, dax_q};
  end

  // determinant operand selection: cofactor expansion along the first row
  always_comb begin
    ci = t_q[3:2];
    ph = t_q[1:0];
    case (ci)
      2'd0:    begin ca = 2'd1; cb = 2'd2; end
      2'd1:    begin ca = 2'd0; cb = 2'd2; end
      default: begin ca = 2'd0; cb = 2'd1; end
    endcase
    ia = 4'd0;
    ib = 4'd0;
    case (ph)
      2'd0:    begin ia = 4'd3 + {2'b00, ca}; ib = 4'd6 + {2'b00, cb}; end
      2'd1:    begin ia = 4'd3 + {2'b00, cb}; ib = 4'd6 + {2'b00, ca}; end
      default: begin ia = {2'b00, ci};        ib = 4'd0;                end
    endcase
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      hcg_pkg::S_MUL: begin
        mul_a = MW'(diff_q);
        mul_b = S_CONST;
      end
      hcg_pkg::S_DMUL: begin
        mul_a = MW'(dm_q[ia]);
        case (ph)
          2'd2:    mul_b = {1'b0, minor_q[L-1:0]};
          2'd3:    mul_b = MW'(minor_q >>> L);
          default: mul_b = MW'(dm_q[ib]);
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    p_d    = (ph == 2'd3) ? (DW'(mul_p) <<< L) : DW'(mul_p);
    dsh_w  = (RW'(det_q) <<< LSH) + RND_HALF;
    rnd_w  = dsh_w >>> RSH;
    vsat_w = sat64(XW'(vol_q));
  end

  hcg_mul #(
    .W(MW)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // next state and result outputs
  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    c_d          = c_q;
    dax_d        = dax_q;
    op_d         = op_q;
    ld_d         = ld_q;
    t_d          = t_q;
    res_o        = '0;
    res_pos_o    = '0;
    res_weight_o = '0;
    rd_addr_o    = ld_q[2:0];
    case (state_q)
      hcg_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = hcg_pkg::S_LOAD;
          ld_d    = '0;
        end
      end
      hcg_pkg::S_LOAD: begin
        ld_d = ld_q + 4'd1;
        if (ld_q == 4'd8) begin
          state_d = hcg_pkg::S_INIT;
          k_d     = '0;
          c_d     = '0;
          dax_d   = DAX_VALUE;
        end
      end
      hcg_pkg::S_INIT: begin
        op_d    = '0;
        state_d = hcg_pkg::S_OP;
      end
      hcg_pkg::S_OP: begin
        if (axis != dax_q) begin
          state_d = hcg_pkg::S_MUL;
        end
      end
      hcg_pkg::S_MUL: begin
        state_d = hcg_pkg::S_ACC;
      end
      hcg_pkg::S_ACC: begin
        state_d = hcg_pkg::S_OP;
      end
      hcg_pkg::S_DMUL: begin
        state_d = hcg_pkg::S_DACC;
      end
      hcg_pkg::S_DACC: begin
        t_d     = t_q + 4'd1;
        state_d = (t_q == 4'd11) ? hcg_pkg::S_ROUND : hcg_pkg::S_DMUL;
      end
      hcg_pkg::S_ROUND: begin
        state_d = hcg_pkg::S_EMIT;
      end
      hcg_pkg::S_EMIT: begin
        res_o.valid  = 1'b1;
        res_o.kind   = hcg_pkg::KIND_GAUSS;
        res_o.index  = k_q;
        res_pos_o    = {val_q[2], val_q[1], val_q[0]};
        res_weight_o = wsat_q;
        if (res_take_i) begin
          if (k_q == 3'd7) begin
            state_d = hcg_pkg::S_CENT;
          end else begin
            k_d     = k_q + 3'd1;
            c_d     = '0;
            dax_d   = DAX_VALUE;
            state_d = hcg_pkg::S_INIT;
          end
        end
      end
      hcg_pkg::S_CENT: begin
        res_o.valid  = 1'b1;
        res_o.kind   = hcg_pkg::KIND_CENTROID;
        res_pos_o    = cent_i;
        res_weight_o = vsat_w;
        if (res_take_i) begin
          state_d = hcg_pkg::S_EXT;
        end
      end
      hcg_pkg::S_EXT: begin
        res_o.valid = 1'b1;
        res_o.kind  = hcg_pkg::KIND_EXTENT;
        res_o.last  = 1'b1;
        res_pos_o   = ext_i;
        if (res_take_i) begin
          state_d = hcg_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hcg_pkg::S_IDLE;
      end
    endcase

    // queue step: advance the lerp count or move to the next reduction
    if (q_wr) begin
      state_d = hcg_pkg::S_OP;
      op_d    = op_q + 3'd1;
      if (fin) begin
        state_d = hcg_pkg::S_INIT;
        if (dax_q == DAX_VALUE) begin
          dax_d = 2'd0;
        end else if (dax_q != 2'd2) begin
          dax_d = dax_q + 2'd1;
        end else if (c_q != 2'd2) begin
          c_d   = c_q + 2'd1;
          dax_d = DAX_VALUE;
        end else begin
          t_d     = '0;
          state_d = hcg_pkg::S_DMUL;
        end
      end
    end
  end

  assign busy_o = (state_q != hcg_pkg::S_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcg_pkg::S_IDLE;
      k_q     <= '0;
      c_q     <= '0;
      dax_q   <= DAX_VALUE;
      op_q    <= '0;
      ld_q    <= '0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      c_q     <= c_d;
      dax_q   <= dax_d;
      op_q    <= op_d;
      ld_q    <= ld_d;
      t_q     <= t_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // vertex rows stream in from the ram
    if ((state_q == hcg_pkg::S_LOAD) && (ld_q != 4'd0)) begin
      for (int i = 0; i < 7; i++) begin
        base_q[i] <= base_q[i+1];
      end
      base_q[7] <= rd_data_i;
      vol_q     <= '0;
    end
    // fresh queue with one coordinate of all corners
    if (state_q == hcg_pkg::S_INIT) begin
      for (int i = 0; i < 8; i++) begin
        q_q[i] <= E'($signed(base_q[i][c_q*C +: C]));
      end
    end
    if ((state_q == hcg_pkg::S_OP) && (axis != dax_q)) begin
      diff_q <= diff_w;
      sum_q  <= sum_w;
    end
    // pop two, push one
    if (q_wr) begin
      for (int i = 0; i < 6; i++) begin
        q_q[i] <= (wpos == 3'(i)) ? r_w : q_q[i+2];
      end
      if (wpos == 3'd6) begin
        q_q[6] <= r_w;
      end
    end
    if (fin) begin
      if (dax_q == DAX_VALUE) begin
        val_q[c_q] <= r_w[C-1:0];
      end else begin
        dm_q[dm_idx] <= r_w;
      end
    end
    // determinant accumulation
    if ((state_q == hcg_pkg::S_DMUL) && (t_q == 4'd0)) begin
      det_q <= '0;
    end
    if (state_q == hcg_pkg::S_DACC) begin
      case (ph)
        2'd0:    minor_q <= NW'(mul_p);
        2'd1:    minor_q <= minor_q - NW'(mul_p);
        default: det_q   <= (ci == 2'd1) ? det_q - p_d : det_q + p_d;
      endcase
    end
    if (state_q == hcg_pkg::S_ROUND) begin
      vol_q  <= vol_q + VW'(rnd_w);
      wsat_q <= sat64(XW'(rnd_w));
    end
  end

  `ASSERT_IMPLIES(a_start_idle, clk_i, rst_ni, start_i, state_q == hcg_pkg::S_IDLE, "cell start while busy")
  `ASSERT_NEXT(a_ext_ends, clk_i, rst_ni, (state_q == hcg_pkg::S_EXT) && res_take_i, state_q == hcg_pkg::S_IDLE, "engine did not finish after extent")
  `ASSERT_IMPLIES(a_dacc_order, clk_i, rst_ni, state_q == hcg_pkg::S_DACC, $past(state_q) == hcg_pkg::S_DMUL, "determinant accumulate without product")

endmodule

### src/hex_cell_gauss_geometry.sv
// top level of the hexahedral cell gauss point geometry block
//
// Vertices of a cell are taken one per cycle while the input is not stalled, in
// trilinear order; the first seven give no result. After the eighth the block
// stalls its input and one shared multiplier under a sequencer works out the
// eight gauss points (position and jacobian determinant), then the centroid with
// volume and the bounding extent. The work is set by the lerp chain (each lerp
// passes the operand, multiply and accumulate states, a plain difference only the
// operand state) and the twelve determinant products, all through the one
// multiplier. An output register holds each result until it is taken.
`include "assert_macros.svh"

module hex_cell_gauss_geometry #(
  parameter int COORD_BITS = hcg_pkg::COORD_BITS,
  parameter int FRAC_BITS  = hcg_pkg::FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic signed [COORD_BITS-1:0] vertex_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [2:0]                   point_index_o,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic signed [COORD_BITS-1:0] out_z_o,
  output logic signed [63:0]           weight_o,
  output logic                         last_o
);

  localparam int C = COORD_BITS;

  logic                 in_xfer;
  logic [2:0]           vcnt_q;
  logic                 eng_busy;
  logic                 start;
  logic [2:0]           rd_addr;
  logic [3*C-1:0]       rd_data;
  logic [2:0][C-1:0]    vtx;
  logic [2:0][C-1:0]    cent, ext;
  hcg_pkg::res_ctrl_t   res;
  logic [2:0][C-1:0]    res_pos;
  logic [63:0]          res_weight;
  logic                 res_take;
  logic                 out_valid_q;
  hcg_pkg::kind_e       out_kind_q;
  logic [2:0]           out_idx_q;
  logic                 out_last_q;
  logic [2:0][C-1:0]    out_pos_q;
  logic [63:0]          out_weight_q;

  assign in_stall_o = eng_busy;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign start      = in_xfer && (vcnt_q == 3'd7);
  assign vtx        = {vertex_z_i, vertex_y_i, vertex_x_i};

  // vertex count within the cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
    end else if (in_xfer) begin
      vcnt_q <= vcnt_q + 3'd1;
    end
  end

  hcg_ram #(
    .WIDTH(3 * C),
    .DEPTH(8)
  ) u_vtx_ram (
    .clk_i  (clk_i),
    .we_i   (in_xfer),
    .waddr_i(vcnt_q),
    .wdata_i(vtx),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  hcg_stats #(
    .COORD_BITS(C)
  ) u_stats (
    .clk_i  (clk_i),
    .we_i   (in_xfer),
    .first_i(vcnt_q == 3'd0),
    .vtx_i  (vtx),
    .cent_o (cent),
    .ext_o  (ext)
  );

  hcg_engine #(
    .COORD_BITS(C),
    .FRAC_BITS (FRAC_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .cent_i      (cent),
    .ext_i       (ext),
    .res_o       (res),
    .res_pos_o   (res_pos),
    .res_weight_o(res_weight),
    .res_take_i  (res_take),
    .busy_o      (eng_busy)
  );

  // output register loads when empty or being drained
  assign res_take = res.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_kind_q   <= res.kind;
      out_idx_q    <= res.index;
      out_last_q   <= res.last;
      out_pos_q    <= res_pos;
      out_weight_q <= res_weight;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign point_index_o = out_idx_q;
  assign out_x_o       = out_pos_q[0];
  assign out_y_o       = out_pos_q[1];
  assign out_z_o       = out_pos_q[2];
  assign weight_o      = out_weight_q;
  assign last_o        = out_last_q;

  `ASSERT_IMPLIES(a_busy_count, clk_i, rst_ni, eng_busy, vcnt_q == 3'd0, "vertex count not at cell start while busy")
  `ASSERT_IMPLIES(a_last_kind, clk_i, rst_ni, out_valid_o && last_o, kind_o == hcg_pkg::KIND_EXTENT, "last flag on a result other than extent")

endmodule

### verif/tb_top.sv
// hex cell gauss geometry testbench: directed and randomized cells checked by a scoreboard
`timescale 1ns / 1ps

module tb_top;

  localparam int       WB        = 30;           // weight fraction bits, min(62 - 32, 31)
  localparam int       RSH       = 19;           // 3*16 + 3 - 32
  localparam int       RANDCELLS = 36;
  localparam longint   CYC_LIMIT = 1000000;
  localparam logic signed [127:0] SAT_HI = 128'sh7fff_ffff_ffff_ffff;
  localparam logic signed [127:0] SAT_LO = -SAT_HI - 1;

  typedef struct {
    hcg_pkg::kind_e kind;
    logic [2:0]     idx;
    logic [31:0]    x, y, z;
    logic [63:0]    w;
    logic           last;
  } cell_res_t;

  // largest r with r*r <= n
  function automatic longint root_floor(input longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= n) r = r | (64'd1 << b);
    end
    return longint'(r);
  endfunction

  function automatic logic signed [127:0] sat64(input logic signed [127:0] v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  class cell_scoreboard;
    longint    corners[8][3];
    int        n_held;
    cell_res_t pending[$];
    int        errors;
    longint    w_hi, w_lo;

    function new();
      longint s;
      s      = root_floor((64'd1 << (2 * WB - 2)) / 3);
      w_hi   = (64'sd1 <<< (WB - 1)) + s;
      w_lo   = (64'sd1 <<< (WB - 1)) - s;
      n_held = 0;
      errors = 0;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function longint blend(longint lo, longint hi, longint wl, longint wh);
      longint s;
      s = wl * lo + wh * hi + (64'sd1 <<< (WB - 1));
      return s >>> WB;
    endfunction

    // trilinear collapse of one coordinate at point k, differentiating along dax (<3)
    function longint collapse(int c, int k, int dax);
      longint b[8];
      int     n;
      for (int i = 0; i < 8; i++) b[i] = corners[i][c];
      n = 8;
      for (int ax = 0; ax < 3; ax++) begin
        n = n / 2;
        for (int j = 0; j < n; j++) begin
          if (ax == dax) b[j] = b[2*j+1] - b[2*j];
          else if ((k >> ax) & 1) b[j] = blend(b[2*j], b[2*j+1], w_lo, w_hi);
          else b[j] = blend(b[2*j], b[2*j+1], w_hi, w_lo);
        end
      end
      return b[0];
    endfunction

    function void predict_cell();
      logic signed [127:0] d[3][3];
      logic signed [127:0] det, vol;
      longint    pos[3];
      longint    sum, mn, mx;
      cell_res_t r;
      vol = 0;
      for (int k = 0; k < 8; k++) begin
        for (int c = 0; c < 3; c++) begin
          pos[c] = collapse(c, k, 3);
          for (int a = 0; a < 3; a++) d[c][a] = collapse(c, k, a);
        end
        det = d[0][0] * (d[1][1] * d[2][2] - d[1][2] * d[2][1])
            - d[0][1] * (d[1][0] * d[2][2] - d[1][2] * d[2][0])
            + d[0][2] * (d[1][0] * d[2][1] - d[1][1] * d[2][0]);
        det = (det + (128'sd1 <<< (RSH - 1))) >>> RSH;
        vol = vol + det;
        r.kind = hcg_pkg::KIND_GAUSS; r.idx = k[2:0]; r.last = 1'b0;
        r.x = pos[0][31:0]; r.y = pos[1][31:0]; r.z = pos[2][31:0];
        r.w = 64'(sat64(det));
        pending.insert(pending.size(), r);
      end
      // centroid and volume
      for (int c = 0; c < 3; c++) begin
        sum = 0;
        for (int i = 0; i < 8; i++) sum += corners[i][c];
        pos[c] = (sum + 4) >>> 3;
      end
      r.kind = hcg_pkg::KIND_CENTROID; r.idx = 3'd0; r.last = 1'b0;
      r.x = pos[0][31:0]; r.y = pos[1][31:0]; r.z = pos[2][31:0];
      r.w = 64'(sat64(vol));
      pending.insert(pending.size(), r);
      // bounding extent, saturated to the coordinate range
      for (int c = 0; c < 3; c++) begin
        mn = corners[0][c]; mx = corners[0][c];
        for (int i = 1; i < 8; i++) begin
          if (corners[i][c] < mn) mn = corners[i][c];
          if (corners[i][c] > mx) mx = corners[i][c];
        end
        pos[c] = (mx - mn > 64'sh7fff_ffff) ? 64'sh7fff_ffff : mx - mn;
      end
      r.kind = hcg_pkg::KIND_EXTENT; r.idx = 3'd0; r.last = 1'b1;
      r.x = pos[0][31:0]; r.y = pos[1][31:0]; r.z = pos[2][31:0];
      r.w = 64'd0;
      pending.insert(pending.size(), r);
    endfunction

    function void note_vertex(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
      corners[n_held][0] = longint'(x);
      corners[n_held][1] = longint'(y);
      corners[n_held][2] = longint'(z);
      n_held++;
      if (n_held == 8) begin
        n_held = 0;
        predict_cell();
      end
    endfunction

    task check(cell_res_t got);
      cell_res_t want;
      if (pending.size() == 0) begin
        report("unexpected result", {62'd0, got.kind}, 64'd0);
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind) report("kind", 64'(got.kind), 64'(want.kind));
      if (got.idx != want.idx) report("point_index", 64'(got.idx), 64'(want.idx));
      if (got.x != want.x) report("out_x", 64'(got.x), 64'(want.x));
      if (got.y != want.y) report("out_y", 64'(got.y), 64'(want.y));
      if (got.z != want.z) report("out_z", 64'(got.z), 64'(want.z));
      if (got.w != want.w) report("weight", got.w, want.w);
      if (got.last != want.last) report("last", 64'(got.last), 64'(want.last));
    endtask
  endclass

  logic                clk_i, rst_ni;
  logic                in_valid_i, in_stall_o;
  logic signed [31:0]  vertex_x_i, vertex_y_i, vertex_z_i;
  logic                out_valid_o, out_stall_i;
  logic [1:0]          kind_o;
  logic [2:0]          point_index_o;
  logic signed [31:0]  out_x_o, out_y_o, out_z_o;
  logic signed [63:0]  weight_o;
  logic                last_o;

  cell_scoreboard sb;
  longint cycles;
  logic   hold_off;
  logic   out_quiet;
  int     rx_wait;
  logic   sender_quiet;

  hex_cell_gauss_geometry u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .vertex_x_i, .vertex_y_i, .vertex_z_i,
    .out_valid_o, .out_stall_i, .kind_o, .point_index_o,
    .out_x_o, .out_y_o, .out_z_o, .weight_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall per transfer, plus the long hold-off
  initial begin
    out_stall_i = 1'b1;
    out_quiet   = 1'b0;
    rx_wait     = 0;
  end
  always @(posedge clk_i) begin
    cell_res_t r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        r.kind = hcg_pkg::kind_e'(kind_o); r.idx = point_index_o;
        r.x = out_x_o; r.y = out_y_o; r.z = out_z_o;
        r.w = weight_o; r.last = last_o;
        sb.check(r);
        if (last_o) out_quiet = ($urandom_range(0, 3) == 0);
        rx_wait = out_quiet ? 0 : $urandom_range(0, 13);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall_i <= hold_off || (rx_wait > 0);
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    hold_off = 1'b0;
    wait (cycles > 20000);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (6000) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // one vertex transfer, after a random gap unless the sender is quiet
  task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_x_i <= x;
    vertex_y_i <= y;
    vertex_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_vertex(x, y, z);
  endtask

  // axis-aligned box, corners lo/hi per axis
  task automatic send_box(input logic signed [31:0] lx, input logic signed [31:0] hx,
                          input logic signed [31:0] ly, input logic signed [31:0] hy,
                          input logic signed [31:0] lz, input logic signed [31:0] hz);
    for (int n = 0; n < 8; n++)
      send_vertex(n[0] ? hx : lx, n[1] ? hy : ly, n[2] ? hz : lz);
  endtask

  // perturbed box with random base, size, sign and corner jitter
  task automatic send_jittered_cell();
    logic signed [31:0] base[3], size[3], p[3];
    int jit;
    jit = 1 << $urandom_range(0, 16);
    for (int c = 0; c < 3; c++) begin
      base[c] = $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      size[c] = $urandom_range(1, 1 << $urandom_range(4, 26));
      if ($urandom_range(0, 5) == 0) size[c] = -size[c];
    end
    for (int n = 0; n < 8; n++) begin
      for (int c = 0; c < 3; c++)
        p[c] = base[c] + (n[c] ? size[c] : 0) + $signed($urandom_range(0, jit)) - jit / 2;
      send_vertex(p[0], p[1], p[2]);
    end
  endtask

  initial begin
    sb = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    vertex_x_i   = '0;
    vertex_y_i   = '0;
    vertex_z_i   = '0;
    sender_quiet = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unit cube, extreme corners (saturating extent and weights), flat cell
    send_box(32'sh0, 32'sh1_0000, 32'sh0, 32'sh1_0000, 32'sh0, 32'sh1_0000);
    send_box(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
             32'sh7fff_ffff, 32'sh8000_0000);
    send_box(32'sh1234, 32'sh5_0000, -32'sh3_0000, 32'sh2_0000, 32'sh7, 32'sh7);

    // random cells: mostly jittered boxes, some fully random corners
    for (int i = 0; i < RANDCELLS; i++) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        for (int n = 0; n < 8; n++) send_vertex($urandom, $urandom, $urandom);
      end else begin
        send_jittered_cell();
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/hcg_pkg.sv
src/hcg_ram.sv
src/hcg_mul.sv
src/hcg_stats.sv
src/hcg_engine.sv
src/hex_cell_gauss_geometry.sv
verif/tb_top.sv
